// File: design/trial_division_factorizer_core_macros.svh
// Assertion macros for the factorizer core
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdf check failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define TDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdf check failed: next-cycle implication");

`endif

// File: design/tdf_pkg.sv
package tdf_pkg;

  localparam int NUM_WIDTH_DEF = 24;
  localparam int EXP_WIDTH     = 5;
  localparam int MAX_RESULTS   = 8;

endpackage

// File: design/tdf_divider.sv
module tdf_divider #(
  parameter int NUM_WIDTH = tdf_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [NUM_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [NUM_WIDTH-1:0] quo_r;
  logic [NUM_WIDTH-1:0] rem_r;
  logic [NUM_WIDTH-1:0] dvs_r;

  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   diff;
  logic [NUM_WIDTH-1:0] rem_nxt;
  logic [NUM_WIDTH-1:0] quo_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[NUM_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[NUM_WIDTH]) begin
      rem_nxt = diff[NUM_WIDTH-1:0];
      quo_nxt = {quo_r[NUM_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[NUM_WIDTH-1:0];
      quo_nxt = {quo_r[NUM_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: design/trial_division_factorizer_core.sv
// For an input of 0 or 1, the request goes straight from ST_IDLE to ST_FIN, and
// out_valid rises from ST_FIN once the output is not stalled. Otherwise each trial
// divisor is tested by divisions in the shared divider; each divisor needs
// (exponent+1) divisions, for divisors 2..floor(sqrt(residual)), while fewer
// than MAX_RESULTS results have been found.
// Throughput: one item at a time; in_ready is high only between runs.
`include "trial_division_factorizer_core_macros.svh"

module trial_division_factorizer_core #(
  parameter int NUM_WIDTH = tdf_pkg::NUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [NUM_WIDTH-1:0]           in_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [NUM_WIDTH-1:0]           out_factor_prime,
  output logic [tdf_pkg::EXP_WIDTH-1:0]  out_exponent,
  output logic                           out_no_factors,
  output logic                           out_last
);

  localparam int EW   = tdf_pkg::EXP_WIDTH;
  localparam int SQ_W = NUM_WIDTH + 2;
  localparam int CN_W = $clog2(tdf_pkg::MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NEXT,
    ST_TAIL,
    ST_FIN
  } state_t;

  state_t               state_r;
  logic [NUM_WIDTH-1:0] res_r;
  logic [NUM_WIDTH-1:0] dvs_r;
  logic [SQ_W-1:0]      sq_r;
  logic [EW-1:0]        exp_r;
  logic [CN_W-1:0]      cnt_r;

  logic                 pend_valid_r;
  logic [NUM_WIDTH-1:0] pend_prime_r;
  logic [EW-1:0]        pend_exp_r;
  logic                 pend_nof_r;

  logic                 out_valid_r;
  logic [NUM_WIDTH-1:0] out_prime_r;
  logic [EW-1:0]        out_exp_r;
  logic                 out_nof_r;
  logic                 out_last_r;

  logic                 div_start;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;

  logic                 out_busy;
  logic                 push_ok;
  logic                 cnt_room;
  logic [NUM_WIDTH-1:0] dvs_nxt;
  logic [SQ_W-1:0]      sq_nxt;

  tdf_divider #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (res_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign div_start = (state_r == ST_DIV_START);
  assign out_busy  = out_valid_r && !out_ready;
  assign push_ok   = !(pend_valid_r && out_busy);
  assign cnt_room  = (cnt_r < CN_W'(tdf_pkg::MAX_RESULTS));
  assign dvs_nxt   = dvs_r + NUM_WIDTH'(1);
  // (d+1)^2 = d^2 + 2d + 1
  assign sq_nxt    = sq_r + {1'b0, dvs_r, 1'b0} + SQ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            res_r        <= in_number;
            dvs_r        <= NUM_WIDTH'(2);
            sq_r         <= SQ_W'(4);
            cnt_r        <= '0;
            exp_r        <= '0;
            pend_valid_r <= 1'b0;
            if (in_number[NUM_WIDTH-1:1] == '0) begin
              pend_prime_r <= '0;
              pend_exp_r   <= '0;
              pend_nof_r   <= 1'b1;
              pend_valid_r <= 1'b1;
              state_r      <= ST_FIN;
            end else begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if ((sq_r <= {2'b00, res_r}) && cnt_room) begin
            exp_r   <= '0;
            state_r <= ST_DIV_START;
          end else begin
            state_r <= ST_TAIL;
          end
        end
        ST_DIV_START: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (div_rem == '0) begin
              res_r   <= div_quo;
              exp_r   <= exp_r + EW'(1);
              state_r <= ST_DIV_START;
            end else begin
              state_r <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          if (exp_r == '0) begin
            dvs_r   <= dvs_nxt;
            sq_r    <= sq_nxt;
            state_r <= ST_CHECK;
          end else if (push_ok) begin
            // hand the held result on; its last flag is now known to be clear
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_prime_r <= pend_prime_r;
              out_exp_r   <= pend_exp_r;
              out_nof_r   <= pend_nof_r;
              out_last_r  <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_prime_r <= dvs_r;
            pend_exp_r   <= exp_r;
            pend_nof_r   <= 1'b0;
            cnt_r        <= cnt_r + CN_W'(1);
            dvs_r        <= dvs_nxt;
            sq_r         <= sq_nxt;
            state_r      <= ST_CHECK;
          end
        end
        ST_TAIL: begin
          if ((res_r > NUM_WIDTH'(1)) && cnt_room) begin
            // leftover above one is a prime
            if (push_ok) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_prime_r <= pend_prime_r;
                out_exp_r   <= pend_exp_r;
                out_nof_r   <= pend_nof_r;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_prime_r <= res_r;
              pend_exp_r   <= EW'(1);
              pend_nof_r   <= 1'b0;
              cnt_r        <= cnt_r + CN_W'(1);
              res_r        <= NUM_WIDTH'(1);
              state_r      <= ST_FIN;
            end
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_busy) begin
            out_valid_r  <= 1'b1;
            out_prime_r  <= pend_prime_r;
            out_exp_r    <= pend_exp_r;
            out_nof_r    <= pend_nof_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_factor_prime = out_prime_r;
  assign out_exponent     = out_exp_r;
  assign out_no_factors   = out_nof_r;
  assign out_last         = out_last_r;

  `TDF_ASSERT_NOW(a_idle_nothing_held, clk, rst_n, state_r == ST_IDLE, !pend_valid_r)
  `TDF_ASSERT_NOW(a_div_done_waited, clk, rst_n, div_done, state_r == ST_DIV_WAIT)
  `TDF_ASSERT_NOW(a_nof_is_last, clk, rst_n, out_valid_r && out_nof_r, out_last_r)
  `TDF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// File: sim/testbench.sv
module testbench;

  localparam int NUM_W = tdf_pkg::NUM_WIDTH_DEF;
  localparam int EXP_W = tdf_pkg::EXP_WIDTH;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  typedef struct packed {
    logic [NUM_W-1:0] prime;
    logic [EXP_W-1:0] exponent;
    logic             no_factors;
    logic             last;
  } factor_t;

  typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_SINK_STALLS, PH_BOTH, PH_DRAIN} traffic_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [NUM_W-1:0] in_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [NUM_W-1:0] out_factor_prime;
  logic [EXP_W-1:0] out_exponent;
  logic             out_no_factors;
  logic             out_last;

  logic [NUM_W-1:0] pending_numbers[$];
  factor_t          expected_factors[$];
  int               total_items = 1;
  int               directed_count = 0;
  int               sent_count = 0;
  int               runs_taken = 0;
  int               runs_done = 0;
  int               mismatches = 0;
  longint           cycle_count = 0;
  longint           cycle_limit = 64'd100_000_000;
  traffic_t         traffic_phase = PH_STEADY;

  int unsigned small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

  trial_division_factorizer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_factor_prime (out_factor_prime),
    .out_exponent     (out_exponent),
    .out_no_factors   (out_no_factors),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on %s: got %0d, want %0d (run %0d)", what, got, want, runs_done);
    mismatches++;
  endtask

  // Factor by trial divisors; queue the results when record is set.
  // Returns a rough cycle cost of the run, used only for the timeout.
  function automatic int factorize(input logic [NUM_W-1:0] value, input bit record);
    longint unsigned rest;
    longint unsigned divisor;
    logic [EXP_W-1:0] mult;
    int               found;
    int               cost;
    factor_t          held;
    factor_t          f;
    rest = value;
    divisor = 2;
    found = 0;
    cost = 16;
    held = '0;
    if (rest <= 1) begin
      held.no_factors = 1'b1;
      held.last = 1'b1;
      if (record) expected_factors = {expected_factors, held};
      return cost;
    end
    while (divisor * divisor <= rest && found < tdf_pkg::MAX_RESULTS) begin
      mult = '0;
      cost += NUM_W + 4;
      while (rest % divisor == 0) begin
        rest = rest / divisor;
        mult = mult + EXP_W'(1);
        cost += NUM_W + 2;
      end
      if (mult != 0) begin
        f = '0;
        f.prime = NUM_W'(divisor);
        f.exponent = mult;
        // keep the newest result back so its last flag can still be set
        if (found != 0 && record) expected_factors = {expected_factors, held};
        held = f;
        found++;
      end
      divisor++;
    end
    if (rest > 1 && found < tdf_pkg::MAX_RESULTS) begin
      f = '0;
      f.prime = NUM_W'(rest);
      f.exponent = EXP_W'(1);
      if (found != 0 && record) expected_factors = {expected_factors, held};
      held = f;
      found++;
    end
    held.last = 1'b1;
    if (record) expected_factors = {expected_factors, held};
    return cost + 8 * found;
  endfunction

  function automatic logic [NUM_W-1:0] draw_number();
    int unsigned v;
    int unsigned p;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 3) return NUM_W'($urandom());
    if (kind < 8) return NUM_W'($urandom_range(0, 1));
    if (kind < 40) return NUM_W'($urandom_range(0, (1 << $urandom_range(2, 14)) - 1));
    // smooth numbers reach the upper bits without long divisor walks
    v = (kind < 55) ? $urandom_range(2, 1500) : 1;
    repeat ($urandom_range(1, 16)) begin
      p = small_primes[$urandom_range(0, 14)];
      if (v * p <= NUM_MAX) v = v * p;
    end
    return NUM_W'(v);
  endfunction

  function automatic traffic_t phase_of(input int idx);
    return traffic_t'((idx * 4) / total_items);
  endfunction

  // Request driver
  always @(posedge clk) begin : drive_requests
    bit took_now;
    bit gap;
    bit hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_number <= '0;
    end else begin
      took_now = in_valid && in_ready;
      if (took_now) begin
        void'(factorize(in_number, 1'b1));
        runs_taken <= runs_taken + 1;
      end
      gap = 1'b0;
      case (traffic_phase)
        PH_SEND_GAPS: gap = ($urandom_range(0, 99) < 52);
        PH_BOTH:      gap = ($urandom_range(0, 99) < 22);
        default:      gap = 1'b0;
      endcase
      // drain the block before the random part and at each phase change
      hold = (sent_count > 0) &&
             (sent_count == directed_count ||
              phase_of(sent_count) != phase_of(sent_count - 1)) &&
             (took_now || runs_taken != runs_done);
      if (!in_valid || in_ready) begin
        if (pending_numbers.size() != 0 && !gap && !hold) begin
          in_valid <= 1'b1;
          in_number <= pending_numbers.pop_front();
          sent_count++;
          traffic_phase <= phase_of(sent_count);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_results
    factor_t want;
    int      stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (traffic_phase)
        PH_SINK_STALLS: stall_pct = 52;
        PH_BOTH:        stall_pct = 22;
        default:        stall_pct = 0;
      endcase
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (expected_factors.size() == 0) begin
          report_mismatch("unexpected result, factor_prime", out_factor_prime, 0);
        end else begin
          want = expected_factors.pop_front();
          if (out_factor_prime !== want.prime)
            report_mismatch("factor_prime", out_factor_prime, want.prime);
          if (out_exponent !== want.exponent)
            report_mismatch("exponent", out_exponent, want.exponent);
          if (out_no_factors !== want.no_factors)
            report_mismatch("no_factors", out_no_factors, want.no_factors);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
          if (want.last) runs_done <= runs_done + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : run_stimulus
    logic [NUM_W-1:0] corner_numbers[20];
    logic [NUM_W-1:0] v;
    longint           cost_total;
    corner_numbers = '{
      24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd6, 24'd9, 24'd25, 24'd49, 24'd97,
      24'd12, 24'hFFFFFF, 24'h800000, 24'h800001, 24'hAAAAAA, 24'h555555,
      24'd9699690,    // eight distinct primes
      24'd14348907,   // 3**15
      24'd16777213,   // largest prime in range
      24'd16777207    // two primes near the square root limit
    };
    cost_total = 0;
    foreach (corner_numbers[i]) begin
      pending_numbers = {pending_numbers, corner_numbers[i]};
      cost_total += factorize(corner_numbers[i], 1'b0);
    end
    directed_count = pending_numbers.size();
    repeat (80) begin
      v = draw_number();
      pending_numbers = {pending_numbers, v};
      cost_total += factorize(v, 1'b0);
    end
    total_items = pending_numbers.size();
    cycle_limit = 4 * cost_total + 500 * total_items + 10000;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_numbers.size() != 0 || in_valid || runs_taken != runs_done);
    repeat (50) @(posedge clk);

    if (expected_factors.size() != 0)
      report_mismatch("results never delivered", 0, expected_factors.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
